// ===== rtl/core/mcr_pkg.sv =====
// Package for the midpoint circle rasteriser core.
// Holds field widths, operation codes, stepping constants and the group record.
// No dependencies.
package mcr_pkg;

  localparam int CW   = 15;  // centre coordinate
  localparam int RW   = 14;  // radius
  localparam int AW   = 15;  // along / across
  localparam int DW   = 20;  // decision variable
  localparam int COLW = 32;  // colour
  localparam int OW   = 16;  // result coordinate
  localparam int IW   = 3;   // result index within a group

  localparam int DEC_INIT    = 3;
  localparam int DEC_STEP_LO = 6;
  localparam int DEC_STEP_HI = 10;

  localparam logic [IW-1:0] LAST_OUTLINE = 3'd7;
  localparam logic [IW-1:0] LAST_FILL    = 3'd3;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic [AW-1:0]        along;
    logic signed [AW-1:0] across;
    logic                 fill;
    logic [COLW-1:0]      color;
    logic                 finished;
  } group_t;

endpackage

// ===== rtl/core/mcr_if.sv =====
// Channel interfaces of the midpoint circle rasteriser core.
// Command channel and span/point result channel; depends on mcr_pkg.
interface mcr_cmd_if import mcr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  logic signed [CW-1:0] center_x;
  logic signed [CW-1:0] center_y;
  logic [RW-1:0]        radius;
  logic                 fill;
  logic [COLW-1:0]      color;

  modport source (output valid, opcode, center_x, center_y, radius, fill, color,
                  input ready);
  modport sink   (input valid, opcode, center_x, center_y, radius, fill, color,
                  output ready);
endinterface

interface mcr_pix_if import mcr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [OW-1:0] x_begin;
  logic signed [OW-1:0] y_begin;
  logic signed [OW-1:0] x_end;
  logic signed [OW-1:0] y_end;
  logic [COLW-1:0]      pixel_color;
  logic                 last;
  logic                 finished;

  modport source (output valid, x_begin, y_begin, x_end, y_end, pixel_color, last,
                  finished, input ready);
  modport sink   (input valid, x_begin, y_begin, x_end, y_end, pixel_color, last,
                  finished, output ready);
endinterface

// ===== rtl/core/mcr_stepper.sv =====
// Circle state and midpoint decision update, one step per command transaction.
// Hands the pre-advance snapshot of each step to the emitter; depends on mcr_pkg, mcr_if.
module mcr_stepper import mcr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  mcr_cmd_if.sink     cmd,
  input  logic        take,
  output group_t      grp,
  output logic        grp_valid
);

  logic signed [CW-1:0] cx;
  logic signed [CW-1:0] cy;
  logic [AW-1:0]        along;
  logic signed [AW-1:0] across;
  logic [DW-1:0]        decision;
  logic                 fill_mode;
  logic [COLW-1:0]      draw_color;
  logic                 active;

  logic                 is_start;
  logic                 fire;
  logic signed [CW-1:0] cur_cx;
  logic signed [CW-1:0] cur_cy;
  logic [AW-1:0]        cur_along;
  logic signed [AW-1:0] cur_across;
  logic [DW-1:0]        cur_dec;
  logic                 cur_fill;
  logic [COLW-1:0]      cur_color;
  logic [AW-1:0]        along_next;
  logic signed [AW-1:0] across_next;
  logic [DW-1:0]        decision_next;
  logic                 done;

  assign cmd.ready = take;
  assign is_start  = (op_t'(cmd.opcode) == OP_START);
  assign fire      = cmd.valid && take && (is_start || active);

  always_comb begin
    if (is_start) begin
      cur_cx     = cmd.center_x;
      cur_cy     = cmd.center_y;
      cur_along  = '0;
      cur_across = $signed({1'b0, cmd.radius});
      cur_dec    = DW'(DEC_INIT) - (DW'(cmd.radius) << 1);
      cur_fill   = cmd.fill;
      cur_color  = cmd.color;
    end else begin
      cur_cx     = cx;
      cur_cy     = cy;
      cur_along  = along;
      cur_across = across;
      cur_dec    = decision;
      cur_fill   = fill_mode;
      cur_color  = draw_color;
    end
  end

  always_comb begin
    along_next = cur_along + AW'(1);
    if (cur_dec[DW-1]) begin
      decision_next = cur_dec + (DW'(along_next) << 2) + DW'(DEC_STEP_LO);
      across_next   = cur_across;
    end else begin
      decision_next = cur_dec + ((DW'(along_next) - DW'(cur_across)) << 2)
                      + DW'(DEC_STEP_HI);
      across_next   = cur_across - AW'(1);
    end
    done = $signed({2'b00, along_next}) >
           $signed({across_next[AW-1], across_next[AW-1], across_next});
  end

  always_comb begin
    grp.cx       = cur_cx;
    grp.cy       = cur_cy;
    grp.along    = cur_along;
    grp.across   = cur_across;
    grp.fill     = cur_fill;
    grp.color    = cur_color;
    grp.finished = done;
    grp_valid    = fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cx         <= '0;
      cy         <= '0;
      along      <= '0;
      across     <= '0;
      decision   <= '0;
      fill_mode  <= 1'b0;
      draw_color <= '0;
      active     <= 1'b0;
    end else if (fire) begin
      cx         <= cur_cx;
      cy         <= cur_cy;
      along      <= along_next;
      across     <= across_next;
      decision   <= decision_next;
      fill_mode  <= cur_fill;
      draw_color <= cur_color;
      active     <= !done;
    end
  end

endmodule

// ===== rtl/core/mcr_emitter.sv =====
// Group register and result register: expands one step into four spans or eight points.
// One result per cycle onto the result channel while pix is not stalled; depends on mcr_pkg, mcr_if.
module mcr_emitter import mcr_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  group_t      grp_in,
  input  logic        grp_in_valid,
  output logic        take,
  mcr_pix_if.source   pix
);

  localparam int SW = (COORD_BITS > CW + 2) ? COORD_BITS : CW + 2;
  localparam int EW = (COORD_BITS > OW) ? COORD_BITS : OW;

  group_t          grp;
  logic            grp_valid;
  logic [IW-1:0]   idx;

  logic [IW-1:0]   idx_last;
  logic            out_free;
  logic            load;
  logic            load_last;
  logic signed [AW:0] off_a;
  logic signed [AW:0] off_c;
  logic [OW-1:0]   xpa, xma, xpc, xmc, ypa, yma, ypc, ymc;
  logic [OW-1:0]   xb, yb, xe, ye;

  function automatic logic [OW-1:0] crd(input logic signed [CW-1:0] base,
                                        input logic signed [AW:0] off,
                                        input logic neg);
    logic signed [SW-1:0]         sum;
    logic signed [COORD_BITS-1:0] wrapped;
    logic signed [EW-1:0]         ext;
    sum     = neg ? (SW'(base) - SW'(off)) : (SW'(base) + SW'(off));
    wrapped = sum[COORD_BITS-1:0];
    ext     = EW'(wrapped);
    return ext[OW-1:0];
  endfunction

  assign idx_last  = grp.fill ? LAST_FILL : LAST_OUTLINE;
  assign out_free  = !pix.valid || pix.ready;
  assign load      = grp_valid && out_free;
  assign load_last = load && (idx == idx_last);
  assign take      = !grp_valid || load_last;

  assign off_a = $signed({1'b0, grp.along});
  assign off_c = $signed({grp.across[AW-1], grp.across});

  assign xpa = crd(grp.cx, off_a, 1'b0);
  assign xma = crd(grp.cx, off_a, 1'b1);
  assign xpc = crd(grp.cx, off_c, 1'b0);
  assign xmc = crd(grp.cx, off_c, 1'b1);
  assign ypa = crd(grp.cy, off_a, 1'b0);
  assign yma = crd(grp.cy, off_a, 1'b1);
  assign ypc = crd(grp.cy, off_c, 1'b0);
  assign ymc = crd(grp.cy, off_c, 1'b1);

  always_comb begin
    xb = xpa;
    yb = ypc;
    xe = xpa;
    ye = ypc;
    if (grp.fill) begin
      case (idx)
        3'd0:    begin xb = xpc; yb = ypa; xe = xpc; ye = yma; end
        3'd1:    begin xb = xmc; yb = ypa; xe = xmc; ye = yma; end
        3'd2:    begin xb = xpa; yb = ypc; xe = xpa; ye = ymc; end
        default: begin xb = xma; yb = ymc; xe = xma; ye = ypc; end
      endcase
    end else begin
      case (idx)
        3'd0:    begin xb = xpa; yb = ypc; end
        3'd1:    begin xb = xma; yb = ypc; end
        3'd2:    begin xb = xpa; yb = ymc; end
        3'd3:    begin xb = xma; yb = ymc; end
        3'd4:    begin xb = xpc; yb = ypa; end
        3'd5:    begin xb = xpc; yb = yma; end
        3'd6:    begin xb = xmc; yb = ypa; end
        default: begin xb = xmc; yb = yma; end
      endcase
      xe = xb;
      ye = yb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      idx       <= '0;
    end else if (grp_in_valid) begin
      grp_valid <= 1'b1;
      idx       <= '0;
    end else if (load_last) begin
      grp_valid <= 1'b0;
    end else if (load) begin
      idx <= idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (grp_in_valid) begin
      grp <= grp_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix.valid <= 1'b0;
    end else if (load) begin
      pix.valid <= 1'b1;
    end else if (pix.ready) begin
      pix.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pix.x_begin     <= xb;
      pix.y_begin     <= yb;
      pix.x_end       <= xe;
      pix.y_end       <= ye;
      pix.pixel_color <= grp.color;
      pix.last        <= (idx == idx_last);
      pix.finished    <= (idx == idx_last) && grp.finished;
    end
  end

endmodule

// ===== rtl/core/midpoint_circle_rasterizer_core.sv =====
// Top level of the midpoint circle rasteriser: stepper feeding the result emitter.
// Depends on mcr_pkg, mcr_if, mcr_stepper, mcr_emitter.
//
//   channel | dir | transaction
//   --------+-----+---------------------------------------------------------
//   cmd     | in  | opcode, center_x, center_y, radius, fill, color
//   pix     | out | x_begin, y_begin, x_end, y_end, pixel_color, last, finished
//
// A step yields 8 point results (outline) or 4 span results (fill), one per cycle
// while pix is not stalled; the group register sets which of the two it is.
// The next command is taken in the cycle its predecessor's last result enters the
// output register; a step with no circle in progress yields nothing. A command's first
// result passes the group and result registers in turn. rst is synchronous and clears
// the circle state and both valid flags. pix stalls hold the output and back up cmd.
module midpoint_circle_rasterizer_core import mcr_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  mcr_cmd_if.sink   cmd,
  mcr_pix_if.source pix
);

  group_t grp;
  logic   grp_valid;
  logic   take;

  mcr_stepper u_stepper (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .take      (take),
    .grp       (grp),
    .grp_valid (grp_valid)
  );

  mcr_emitter #(
    .COORD_BITS (COORD_BITS)
  ) u_emitter (
    .clk          (clk),
    .rst          (rst),
    .grp_in       (grp),
    .grp_in_valid (grp_valid),
    .take         (take),
    .pix          (pix)
  );

endmodule

// ===== rtl/core/mcr_checker.sv =====
// Port-level checks for the midpoint circle rasteriser core, bound to the top level.
// Depends on mcr_pkg.
module mcr_checker import mcr_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 cmd_valid,
  input logic                 cmd_ready,
  input logic                 pix_valid,
  input logic                 pix_ready,
  input logic signed [OW-1:0] x_begin,
  input logic signed [OW-1:0] x_end,
  input logic [COLW-1:0]      pixel_color,
  input logic                 last,
  input logic                 finished
);

  a_pix_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_ready |=> pix_valid && $stable(x_begin) && $stable(pixel_color))
    else $error("stalled result transaction changed");

  a_vertical: assert property (@(posedge clk) disable iff (rst)
    pix_valid |-> x_begin == x_end)
    else $error("result is neither a point nor a vertical span");

  a_finished_last: assert property (@(posedge clk) disable iff (rst)
    pix_valid && finished |-> last)
    else $error("finished flag on a result that closes no group");

  a_group_colour: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_ready && !last |=> pix_valid && pixel_color == $past(pixel_color))
    else $error("group broken or colour changed inside a group");

  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(pix_valid) |-> $past(cmd_valid && cmd_ready, 2))
    else $error("result appeared without a command transaction");

endmodule

bind midpoint_circle_rasterizer_core mcr_checker u_mcr_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .pix_valid   (pix.valid),
  .pix_ready   (pix.ready),
  .x_begin     (pix.x_begin),
  .x_end       (pix.x_end),
  .pixel_color (pix.pixel_color),
  .last        (pix.last),
  .finished    (pix.finished)
);
